@@ rtl/ccwe_pkg.sv @@
// Shared constants and calendar tables for the calendar clock with edit.
package ccwe_pkg;

	// Time units in seconds.
	localparam int unsigned SEC_PER_DAY  = 86400;
	localparam int unsigned SEC_PER_HOUR = 3600;
	localparam int unsigned SEC_PER_MIN  = 60;
	localparam int unsigned YEAR_SECONDS = 31536000;
	localparam int unsigned COUNT_RESET  = 24055756;
	localparam int unsigned WHEEL_FULL   = 4095;

	// Widths of the working values.
	localparam int unsigned CNT_W = 25;
	localparam int unsigned ACC_W = 26;

	// Start values of the shifted divisor for each restoring division, and
	// the number of quotient bits that each one produces.
	localparam int unsigned DAY_QBITS   = 9;
	localparam int unsigned HOUR_QBITS  = 5;
	localparam int unsigned MIN_QBITS   = 6;
	localparam int unsigned WHEEL_QBITS = 6;
	localparam logic [CNT_W-1:0] DIV_DAY_INIT   = CNT_W'(SEC_PER_DAY << (DAY_QBITS - 1));
	localparam logic [CNT_W-1:0] DIV_HOUR_INIT  = CNT_W'(SEC_PER_HOUR << (HOUR_QBITS - 1));
	localparam logic [CNT_W-1:0] DIV_MIN_INIT   = CNT_W'(SEC_PER_MIN << (MIN_QBITS - 1));
	localparam logic [CNT_W-1:0] DIV_WHEEL_INIT = CNT_W'(WHEEL_FULL << (WHEEL_QBITS - 1));

	// Days of the year before the first of a month; out of range months
	// count as the whole year.
	function automatic logic [8:0] month_start(input logic [3:0] m);
		logic [8:0] d;
		case (m)
			4'd0:    d = 9'd0;
			4'd1:    d = 9'd31;
			4'd2:    d = 9'd59;
			4'd3:    d = 9'd90;
			4'd4:    d = 9'd120;
			4'd5:    d = 9'd151;
			4'd6:    d = 9'd181;
			4'd7:    d = 9'd212;
			4'd8:    d = 9'd243;
			4'd9:    d = 9'd273;
			4'd10:   d = 9'd304;
			4'd11:   d = 9'd334;
			default: d = 9'd365;
		endcase
		return d;
	endfunction

	// Length of a month in a non-leap year; out of range months have none.
	function automatic logic [5:0] month_days(input logic [3:0] m);
		logic [5:0] n;
		case (m) inside
			4'd1:                      n = 6'd28;
			4'd3, 4'd5, 4'd8, 4'd10:   n = 6'd30;
			4'd0, 4'd2, 4'd4, 4'd6,
			4'd7, 4'd9, 4'd11:         n = 6'd31;
			default:                   n = 6'd0;
		endcase
		return n;
	endfunction

endpackage

@@ rtl/calendar_clock_with_edit.sv @@
// Ticks are taken one at a time: in_ready is high only in the idle state, so no new word
// is accepted until the last result has been loaded into the result register. The shared
// restoring divider, which yields one quotient bit per cycle, and the eleven-step month
// scan set how long a tick takes.
// Reset: arst_n clears the count to its start value, all fields, view and edit state to
// zero, and empties the result register.
module calendar_clock_with_edit (
	input  logic        clk,
	input  logic        arst_n,
	input  logic        in_valid,
	output logic        in_ready,
	input  logic        edit_press,
	input  logic        confirm_press,
	input  logic [11:0] wheel,
	output logic        out_valid,
	input  logic        out_ready,
	output logic [3:0]  month,
	output logic [4:0]  day,
	output logic [4:0]  hour,
	output logic [5:0]  minute,
	output logic [5:0]  second,
	output logic [1:0]  view,
	output logic        editing,
	output logic [2:0]  field_sel,
	output logic [24:0] year_seconds
);

	// Sequencer states.
	localparam logic [3:0] ST_IDLE    = 4'd0;
	localparam logic [3:0] ST_COMPOSE = 4'd1;
	localparam logic [3:0] ST_WRAP    = 4'd2;
	localparam logic [3:0] ST_INC     = 4'd3;
	localparam logic [3:0] ST_DIV     = 4'd4;
	localparam logic [3:0] ST_MONTH   = 4'd5;
	localparam logic [3:0] ST_DAYSET  = 4'd6;
	localparam logic [3:0] ST_SCALE   = 4'd7;
	localparam logic [3:0] ST_DONE    = 4'd8;

	// Which division the shared divider is running.
	localparam logic [1:0] PH_DAY   = 2'd0;
	localparam logic [1:0] PH_HOUR  = 2'd1;
	localparam logic [1:0] PH_MIN   = 2'd2;
	localparam logic [1:0] PH_WHEEL = 2'd3;

	// Field that the wheel writes.
	localparam logic [2:0] TGT_NONE  = 3'd0;
	localparam logic [2:0] TGT_MONTH = 3'd1;
	localparam logic [2:0] TGT_DAY   = 3'd2;
	localparam logic [2:0] TGT_HOUR  = 3'd3;
	localparam logic [2:0] TGT_MIN   = 3'd4;
	localparam logic [2:0] TGT_SEC   = 3'd5;

	localparam int unsigned CW = ccwe_pkg::CNT_W;
	localparam int unsigned AW = ccwe_pkg::ACC_W;

	// Architectural state.
	logic [3:0]    state_q;
	logic [CW-1:0] cnt_q;
	logic [3:0]    month_q;
	logic [4:0]    day_q;
	logic [4:0]    hour_q;
	logic [5:0]    minute_q;
	logic [5:0]    second_q;
	logic [1:0]    view_q;
	logic          edit_mode_q;
	logic [2:0]    edit_field_q;
	logic          out_valid_q;

	// Working registers.
	logic [AW-1:0] acc_q;
	logic [8:0]    days_q;
	logic [1:0]    step_q;
	logic [11:0]   wheel_q;
	logic [5:0]    n_q;
	logic [2:0]    tgt_q;
	logic [CW-1:0] rem_q;
	logic [CW-1:0] dvs_q;
	logic [8:0]    quo_q;
	logic [3:0]    dcnt_q;
	logic [1:0]    ph_q;
	logic [8:0]    dd_q;
	logic [3:0]    mi_q;

	// Residue of the count modulo three, one bit per cycle from the top.
	logic [CW-1:0] m3_sr_q;
	logic [4:0]    m3_cnt_q;
	logic [1:0]    m3_res_q;
	logic [2:0]    m3_sum;
	logic [1:0]    m3_nx;

	// Result register.
	logic [3:0]    month_r_q;
	logic [4:0]    day_r_q;
	logic [4:0]    hour_r_q;
	logic [5:0]    minute_r_q;
	logic [5:0]    second_r_q;
	logic [1:0]    view_r_q;
	logic          editing_r_q;
	logic [2:0]    field_r_q;
	logic [CW-1:0] cnt_r_q;

	logic          in_acc;
	logic          out_load;

	// Edit button step, applied first in a tick.
	logic          s1_mode;
	logic [2:0]    s1_field;
	logic [2:0]    s1_field_inc;
	logic [1:0]    s1_view;
	logic [2:0]    s1_tgt;
	logic [5:0]    s1_n;

	// Datapath helpers.
	logic [AW-1:0] addend;
	logic [CW-1:0] inc_cnt;
	logic [CW-1:0] cnt_nx;
	logic          div_ge;
	logic [CW-1:0] rem_nx;
	logic [8:0]    quo_nx;
	logic [5:0]    wres;
	logic [17:0]   wprod;

	assign in_ready = (state_q == ST_IDLE);
	assign in_acc   = in_valid && in_ready;
	assign out_load = (state_q == ST_DONE) && (!out_valid_q || out_ready);

	// Edit button: enter edit mode, or advance the selected field.
	always_comb begin
		s1_mode      = edit_mode_q;
		s1_field     = edit_field_q;
		s1_view      = view_q;
		s1_field_inc = edit_field_q + 3'd1;
		if (edit_press) begin
			if (!edit_mode_q) begin
				s1_view  = 2'd0;
				s1_field = 3'd0;
				s1_mode  = 1'b1;
			end else begin
				s1_field = s1_field_inc;
				if (s1_field_inc == 3'd2) begin
					s1_view = 2'd1;
				end
				if (s1_field_inc >= 3'd5) begin
					s1_field = 3'd0;
					s1_view  = 2'd0;
				end
			end
		end
	end

	// Field and scale factor that the wheel sets in this view.
	always_comb begin
		s1_tgt = TGT_NONE;
		s1_n   = 6'd0;
		if (s1_view == 2'd0) begin
			if (s1_field == 3'd0) begin
				s1_tgt = TGT_MONTH;
				s1_n   = 6'd11;
			end else if (s1_field == 3'd1) begin
				s1_tgt = TGT_DAY;
				s1_n   = ccwe_pkg::month_days(month_q);
			end
		end else if (s1_view == 2'd1) begin
			if (s1_field == 3'd2) begin
				s1_tgt = TGT_HOUR;
				s1_n   = 6'd23;
			end else if (s1_field == 3'd3) begin
				s1_tgt = TGT_MIN;
				s1_n   = 6'd59;
			end else if (s1_field == 3'd4) begin
				s1_tgt = TGT_SEC;
				s1_n   = 6'd59;
			end
		end
	end

	// One weighted field is added per compose step.
	always_comb begin
		case (step_q)
			2'd0:    addend = AW'(minute_q) * AW'(ccwe_pkg::SEC_PER_MIN);
			2'd1:    addend = AW'(hour_q) * AW'(ccwe_pkg::SEC_PER_HOUR);
			default: addend = AW'(days_q) * AW'(ccwe_pkg::SEC_PER_DAY);
		endcase
	end

	// Count advance with the wrap at the end of the year.
	assign inc_cnt = cnt_q + CW'(1);
	assign cnt_nx  = (inc_cnt >= CW'(ccwe_pkg::YEAR_SECONDS)) ? '0 : inc_cnt;

	// Restoring divider step: compare, subtract, shift in one quotient bit.
	assign div_ge = (rem_q >= dvs_q);
	assign rem_nx = div_ge ? (rem_q - dvs_q) : rem_q;
	assign quo_nx = {quo_q[7:0], div_ge};
	assign wres   = quo_nx[5:0];
	assign wprod  = 18'(wheel_q) * 18'(n_q);

	// Modulo three residue update for the next count bit.
	assign m3_sum = {m3_res_q, m3_sr_q[CW-1]};
	always_comb begin
		case (m3_sum) inside
			3'd1, 3'd4: m3_nx = 2'd1;
			3'd2, 3'd5: m3_nx = 2'd2;
			default:    m3_nx = 2'd0;
		endcase
	end

	// Sequencer and datapath.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q      <= ST_IDLE;
			cnt_q        <= CW'(ccwe_pkg::COUNT_RESET);
			month_q      <= '0;
			day_q        <= '0;
			hour_q       <= '0;
			minute_q     <= '0;
			second_q     <= '0;
			view_q       <= '0;
			edit_mode_q  <= 1'b0;
			edit_field_q <= '0;
			acc_q        <= '0;
			days_q       <= '0;
			step_q       <= '0;
			wheel_q      <= '0;
			n_q          <= '0;
			tgt_q        <= TGT_NONE;
			rem_q        <= '0;
			dvs_q        <= '0;
			quo_q        <= '0;
			dcnt_q       <= '0;
			ph_q         <= PH_DAY;
			dd_q         <= '0;
			mi_q         <= '0;
		end else begin
			unique case (state_q)
				ST_IDLE: begin
					if (in_acc) begin
						view_q       <= s1_view;
						edit_field_q <= s1_field;
						edit_mode_q  <= confirm_press ? 1'b0 : s1_mode;
						wheel_q      <= wheel;
						n_q          <= s1_n;
						tgt_q        <= s1_tgt;
						if (confirm_press) begin
							acc_q   <= AW'(ccwe_pkg::YEAR_SECONDS - ccwe_pkg::SEC_PER_DAY)
								+ AW'(second_q);
							days_q  <= ccwe_pkg::month_start(month_q) + 9'(day_q);
							step_q  <= 2'd0;
							state_q <= ST_COMPOSE;
						end else if (!s1_mode) begin
							state_q <= ST_INC;
						end else if (s1_tgt != TGT_NONE) begin
							state_q <= ST_SCALE;
						end else begin
							state_q <= ST_DONE;
						end
					end
				end
				ST_COMPOSE: begin
					acc_q  <= acc_q + addend;
					step_q <= step_q + 2'd1;
					if (step_q == 2'd2) begin
						state_q <= ST_WRAP;
					end
				end
				ST_WRAP: begin
					// At most one subtraction brings the sum into the year.
					if (acc_q >= AW'(ccwe_pkg::YEAR_SECONDS)) begin
						acc_q <= acc_q - AW'(ccwe_pkg::YEAR_SECONDS);
					end else begin
						cnt_q   <= acc_q[CW-1:0];
						state_q <= ST_INC;
					end
				end
				ST_INC: begin
					cnt_q   <= cnt_nx;
					rem_q   <= cnt_nx;
					dvs_q   <= ccwe_pkg::DIV_DAY_INIT;
					quo_q   <= '0;
					dcnt_q  <= 4'(ccwe_pkg::DAY_QBITS);
					ph_q    <= PH_DAY;
					state_q <= ST_DIV;
				end
				ST_SCALE: begin
					rem_q   <= CW'(wprod);
					dvs_q   <= ccwe_pkg::DIV_WHEEL_INIT;
					quo_q   <= '0;
					dcnt_q  <= 4'(ccwe_pkg::WHEEL_QBITS);
					ph_q    <= PH_WHEEL;
					state_q <= ST_DIV;
				end
				ST_DIV: begin
					rem_q <= rem_nx;
					if (dcnt_q != 4'd1) begin
						quo_q  <= quo_nx;
						dvs_q  <= dvs_q >> 1;
						dcnt_q <= dcnt_q - 4'd1;
					end else begin
						quo_q <= '0;
						case (ph_q)
							PH_DAY: begin
								dd_q   <= quo_nx;
								dvs_q  <= ccwe_pkg::DIV_HOUR_INIT;
								dcnt_q <= 4'(ccwe_pkg::HOUR_QBITS);
								ph_q   <= PH_HOUR;
							end
							PH_HOUR: begin
								hour_q <= quo_nx[4:0];
								dvs_q  <= ccwe_pkg::DIV_MIN_INIT;
								dcnt_q <= 4'(ccwe_pkg::MIN_QBITS);
								ph_q   <= PH_MIN;
							end
							PH_MIN: begin
								minute_q <= quo_nx[5:0];
								second_q <= rem_nx[5:0];
								month_q  <= '0;
								mi_q     <= 4'd1;
								state_q  <= ST_MONTH;
							end
							default: begin
								// Wheel result goes to the selected field.
								case (tgt_q)
									TGT_MONTH: month_q  <= wres[3:0];
									TGT_DAY:   day_q    <= (wres == 6'd0) ? 5'd1 : wres[4:0];
									TGT_HOUR:  hour_q   <= wres[4:0];
									TGT_MIN:   minute_q <= wres;
									TGT_SEC:   second_q <= wres;
									default:   ;
								endcase
								state_q <= ST_DONE;
							end
						endcase
					end
				end
				ST_MONTH: begin
					// Scan month starts; the last one not past the day wins.
					if (dd_q >= ccwe_pkg::month_start(mi_q)) begin
						month_q <= mi_q;
					end
					if (mi_q == 4'd11) begin
						state_q <= ST_DAYSET;
					end else begin
						mi_q <= mi_q + 4'd1;
					end
				end
				ST_DAYSET: begin
					day_q <= 5'(dd_q - ccwe_pkg::month_start(month_q) + 9'd1);
					if (m3_res_q == 2'd0) begin
						view_q <= view_q + 2'd1;
					end
					state_q <= ST_DONE;
				end
				ST_DONE: begin
					if (out_load) begin
						state_q <= ST_IDLE;
					end
				end
				default: state_q <= ST_IDLE;
			endcase
		end
	end

	// Serial modulo three of the new count, running beside the divider.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			m3_sr_q  <= '0;
			m3_cnt_q <= '0;
			m3_res_q <= '0;
		end else if (state_q == ST_INC) begin
			m3_sr_q  <= cnt_nx;
			m3_cnt_q <= 5'(CW);
			m3_res_q <= '0;
		end else if (m3_cnt_q != 5'd0) begin
			m3_sr_q  <= m3_sr_q << 1;
			m3_cnt_q <= m3_cnt_q - 5'd1;
			m3_res_q <= m3_nx;
		end
	end

	// Result word valid flag.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (out_load) begin
			out_valid_q <= 1'b1;
		end else if (out_ready) begin
			out_valid_q <= 1'b0;
		end
	end

	// Result word payload, a snapshot of the state after the tick.
	always_ff @(posedge clk) begin
		if (out_load) begin
			month_r_q   <= month_q;
			day_r_q     <= day_q;
			hour_r_q    <= hour_q;
			minute_r_q  <= minute_q;
			second_r_q  <= second_q;
			view_r_q    <= view_q;
			editing_r_q <= edit_mode_q;
			field_r_q   <= edit_field_q;
			cnt_r_q     <= cnt_q;
		end
	end

	assign out_valid    = out_valid_q;
	assign month        = month_r_q;
	assign day          = day_r_q;
	assign hour         = hour_r_q;
	assign minute       = minute_r_q;
	assign second       = second_r_q;
	assign view         = view_r_q;
	assign editing      = editing_r_q;
	assign field_sel    = field_r_q;
	assign year_seconds = cnt_r_q;

	// The count never leaves the year.
	a_cnt_in_year: assert property (@(posedge clk) disable iff (!arst_n)
		cnt_q < CW'(ccwe_pkg::YEAR_SECONDS))
		else $error("seconds count out of the year");

	// The field selector stays on one of the five fields.
	a_field_range: assert property (@(posedge clk) disable iff (!arst_n)
		edit_field_q <= 3'd4)
		else $error("edit field out of range");

	// The residue must be complete before the view is updated.
	a_m3_done: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_DAYSET) |-> (m3_cnt_q == 5'd0))
		else $error("modulo three not finished at view update");

	// The day-of-year quotient is always inside the year.
	a_dd_range: assert property (@(posedge clk) disable iff (!arst_n)
		(state_q == ST_MONTH) |-> (dd_q < 9'd365))
		else $error("day of year out of range");

	// In edit mode only the date or time view is shown.
	a_edit_view: assert property (@(posedge clk) disable iff (!arst_n)
		(edit_mode_q && (state_q == ST_IDLE)) |-> (view_q <= 2'd1))
		else $error("edit mode in a temperature view");

endmodule

@@ tb/calendar_clock_with_edit_tb.sv @@
// Self-checking testbench for the calendar clock with field editing.
module calendar_clock_with_edit_tb;

	// Field and view codes as the block reports them.
	typedef enum logic [2:0] {
		FIELD_MONTH, FIELD_DAY, FIELD_HOUR, FIELD_MINUTE, FIELD_SECOND
	} field_e;
	typedef enum logic [1:0] {VIEW_DATE, VIEW_TIME, VIEW_CELSIUS, VIEW_FAHRENHEIT} view_e;

	typedef struct packed {
		logic [3:0]  month;
		logic [4:0]  day;
		logic [4:0]  hour;
		logic [5:0]  minute;
		logic [5:0]  second;
		logic [1:0]  view;
		logic        editing;
		logic [2:0]  field_sel;
		logic [24:0] year_seconds;
	} reading_t;

	// One tick word, with an optional hand-written expectation.
	typedef struct {
		bit         edit;
		bit         confirm;
		logic [11:0] wheel;
		bit         typed;
		reading_t   want;
	} tick_t;

	localparam reading_t NO_READING = '0;
	localparam int N_DIRECTED = 25;
	localparam int N_RANDOM = 1530;
	localparam int unsigned MONTH_FIRST_DAY [12] =
		'{0, 31, 59, 90, 120, 151, 181, 212, 243, 273, 304, 334};
	localparam int unsigned MONTH_LEN [12] =
		'{31, 28, 31, 30, 31, 30, 31, 31, 30, 31, 30, 31};

	logic        clk = 1'b0;
	logic        arst_n = 1'b0;
	logic        in_valid = 1'b0;
	logic        in_ready;
	logic        edit_press = 1'b0;
	logic        confirm_press = 1'b0;
	logic [11:0] wheel = '0;
	logic        out_valid;
	logic        out_ready = 1'b0;
	logic [3:0]  month;
	logic [4:0]  day;
	logic [4:0]  hour;
	logic [5:0]  minute;
	logic [5:0]  second;
	logic [1:0]  view;
	logic        editing;
	logic [2:0]  field_sel;
	logic [24:0] year_seconds;

	calendar_clock_with_edit dut (
		.clk(clk), .arst_n(arst_n),
		.in_valid(in_valid), .in_ready(in_ready),
		.edit_press(edit_press), .confirm_press(confirm_press), .wheel(wheel),
		.out_valid(out_valid), .out_ready(out_ready),
		.month(month), .day(day), .hour(hour), .minute(minute), .second(second),
		.view(view), .editing(editing), .field_sel(field_sel),
		.year_seconds(year_seconds)
	);

	always begin
		#5 clk = 1'b1;
		#5 clk = 1'b0;
	end

	// Model copy of the clock state.
	int unsigned cal_count;
	logic [3:0]  cal_month;
	logic [4:0]  cal_day;
	logic [4:0]  cal_hour;
	logic [5:0]  cal_minute;
	logic [5:0]  cal_second;
	logic [1:0]  cal_view;
	logic        cal_editing;
	logic [2:0]  cal_field;

	tick_t    plan[$];
	reading_t pending_readings[$];
	int       accepted = 0;
	int       results_seen = 0;
	int       fail_count = 0;
	int       in_gap = 0;
	int       stall_left = 0;
	bit       calm_in = 1'b0;
	bit       calm_out = 1'b0;

	// Mostly short gaps, a few long ones, none at all in calm stretches.
	function automatic int pick_gap(input bit calm);
		int r;
		r = $urandom_range(0, 99);
		if (calm || r < 55)
			return 0;
		if (r < 92)
			return $urandom_range(1, 3);
		return $urandom_range(8, 40);
	endfunction

	// Advance the model clock by one tick and return the word it should show.
	function automatic reading_t tick_calendar(input tick_t t);
		int unsigned total;
		int unsigned dd;
		int unsigned rem;
		int unsigned m;
		// Edit button: enter edit mode or step to the next field.
		if (t.edit) begin
			if (!cal_editing) begin
				cal_view = VIEW_DATE;
				cal_field = FIELD_MONTH;
				cal_editing = 1'b1;
			end else begin
				cal_field = cal_field + 3'd1;
				if (cal_field == FIELD_HOUR)
					cal_view = VIEW_TIME;
				if (cal_field > FIELD_SECOND) begin
					cal_field = FIELD_MONTH;
					cal_view = VIEW_DATE;
				end
			end
		end
		// Confirm rebuilds the count; day zero falls back into the previous month.
		if (t.confirm) begin
			total = cal_second + cal_minute * ccwe_pkg::SEC_PER_MIN
				+ cal_hour * ccwe_pkg::SEC_PER_HOUR
				+ (((cal_month < 12) ? MONTH_FIRST_DAY[cal_month] : 365) + cal_day)
				* ccwe_pkg::SEC_PER_DAY + ccwe_pkg::YEAR_SECONDS - ccwe_pkg::SEC_PER_DAY;
			cal_count = total % ccwe_pkg::YEAR_SECONDS;
			cal_editing = 1'b0;
		end
		if (!cal_editing) begin
			// Count one second, wrapping at the end of the year.
			cal_count = (cal_count + 1 >= ccwe_pkg::YEAR_SECONDS) ? 0 : cal_count + 1;
			dd = cal_count / ccwe_pkg::SEC_PER_DAY;
			rem = cal_count % ccwe_pkg::SEC_PER_DAY;
			cal_hour = 5'(rem / ccwe_pkg::SEC_PER_HOUR);
			cal_minute = 6'((rem % ccwe_pkg::SEC_PER_HOUR) / ccwe_pkg::SEC_PER_MIN);
			cal_second = 6'(rem % ccwe_pkg::SEC_PER_MIN);
			m = 0;
			for (int i = 1; i < 12; i++)
				if (dd >= MONTH_FIRST_DAY[i])
					m = i;
			cal_month = 4'(m);
			cal_day = 5'(dd - MONTH_FIRST_DAY[m] + 1);
			if (cal_count % 3 == 0)
				cal_view = cal_view + 2'd1;
		end else if (cal_view == VIEW_DATE) begin
			// Date fields scale the wheel over the month count or month length.
			if (cal_field == FIELD_MONTH) begin
				cal_month = 4'(int'(t.wheel) * 11 / ccwe_pkg::WHEEL_FULL);
			end else if (cal_field == FIELD_DAY) begin
				cal_day = 5'(int'(t.wheel) * ((cal_month < 12) ? MONTH_LEN[cal_month] : 0)
					/ ccwe_pkg::WHEEL_FULL);
				if (cal_day == 0)
					cal_day = 5'd1;
			end
		end else if (cal_view == VIEW_TIME) begin
			if (cal_field == FIELD_HOUR)
				cal_hour = 5'(int'(t.wheel) * 23 / ccwe_pkg::WHEEL_FULL);
			else if (cal_field == FIELD_MINUTE)
				cal_minute = 6'(int'(t.wheel) * 59 / ccwe_pkg::WHEEL_FULL);
			else if (cal_field == FIELD_SECOND)
				cal_second = 6'(int'(t.wheel) * 59 / ccwe_pkg::WHEEL_FULL);
		end
		return '{cal_month, cal_day, cal_hour, cal_minute, cal_second, cal_view,
			cal_editing, cal_field, 25'(cal_count)};
	endfunction

	// Present tick words and record the expected word for each one accepted.
	always @(posedge clk) begin
		reading_t predicted;
		if (arst_n) begin
			if (in_valid && in_ready) begin
				predicted = tick_calendar(plan[accepted]);
				pending_readings.push_back(plan[accepted].typed ? plan[accepted].want
					: predicted);
				accepted++;
				if (accepted % 64 == 0)
					calm_in = ($urandom_range(0, 3) == 0);
				in_gap = pick_gap(calm_in);
			end
			if (!in_valid || in_ready) begin
				if (in_gap > 0) begin
					in_gap--;
					in_valid <= 1'b0;
				end else if (accepted < plan.size()) begin
					edit_press <= plan[accepted].edit;
					confirm_press <= plan[accepted].confirm;
					wheel <= plan[accepted].wheel;
					in_valid <= 1'b1;
				end else begin
					in_valid <= 1'b0;
				end
			end
		end
	end

	// Take result words under random back-pressure and check each field.
	always @(posedge clk) begin
		reading_t want;
		if (arst_n) begin
			if (out_valid && out_ready) begin
				if (pending_readings.size() == 0) begin
					$error("result word arrived with no expectation pending");
					fail_count++;
				end else begin
					want = pending_readings.pop_front();
					if (month !== want.month) begin
						$error("month: expected %0d, got %0d", want.month, month);
						fail_count++;
					end
					if (day !== want.day) begin
						$error("day: expected %0d, got %0d", want.day, day);
						fail_count++;
					end
					if (hour !== want.hour) begin
						$error("hour: expected %0d, got %0d", want.hour, hour);
						fail_count++;
					end
					if (minute !== want.minute) begin
						$error("minute: expected %0d, got %0d", want.minute, minute);
						fail_count++;
					end
					if (second !== want.second) begin
						$error("second: expected %0d, got %0d", want.second, second);
						fail_count++;
					end
					if (view !== want.view) begin
						$error("view: expected %0d, got %0d", want.view, view);
						fail_count++;
					end
					if (editing !== want.editing) begin
						$error("editing: expected %0d, got %0d", want.editing, editing);
						fail_count++;
					end
					if (field_sel !== want.field_sel) begin
						$error("field_sel: expected %0d, got %0d", want.field_sel, field_sel);
						fail_count++;
					end
					if (year_seconds !== want.year_seconds) begin
						$error("year_seconds: expected %0d, got %0d", want.year_seconds,
							year_seconds);
						fail_count++;
					end
				end
				results_seen++;
				if (results_seen % 64 == 0)
					calm_out = ($urandom_range(0, 3) == 0);
			end
			if (stall_left > 0) begin
				stall_left--;
				out_ready <= 1'b0;
			end else begin
				out_ready <= 1'b1;
				stall_left = pick_gap(calm_out);
			end
		end
	end

	initial begin
		tick_t directed_ticks [N_DIRECTED];
		int r;
		int k;
		bit late;
		logic [11:0] w;
		// Directed ticks: confirm with day zero right after reset, a full edit to the
		// last second of the year, wheel extremes, both buttons at once, field wrap
		// in edit mode, and a count that rolls over the year end by itself.
		directed_ticks = '{
			'{1'b0, 1'b1, 12'd0, 1'b1, '{4'd11, 5'd31, 5'd0, 6'd0, 6'd1, VIEW_DATE,
				1'b0, FIELD_MONTH, 25'd31449601}},
			'{1'b1, 1'b0, 12'hFFF, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'hFFF, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'hFFF, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'hFFF, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'hFFF, 1'b0, NO_READING},
			'{1'b0, 1'b1, 12'd0, 1'b1, '{4'd0, 5'd1, 5'd0, 6'd0, 6'd0, VIEW_CELSIUS,
				1'b0, FIELD_SECOND, 25'd0}},
			'{1'b0, 1'b0, 12'hAAA, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'd0, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'd0, 1'b0, NO_READING},
			'{1'b0, 1'b0, 12'h555, 1'b0, NO_READING},
			'{1'b1, 1'b1, 12'hFFF, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'd400, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'hFFF, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'd0, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'd0, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'd4026, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'hFFF, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'hFFF, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'hFFF, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'hFFF, 1'b0, NO_READING},
			'{1'b1, 1'b0, 12'd4026, 1'b0, NO_READING},
			'{1'b0, 1'b1, 12'd0, 1'b1, '{4'd11, 5'd31, 5'd23, 6'd59, 6'd59, VIEW_TIME,
				1'b0, FIELD_SECOND, 25'd31535999}},
			'{1'b0, 1'b0, 12'd0, 1'b1, '{4'd0, 5'd1, 5'd0, 6'd0, 6'd0, VIEW_CELSIUS,
				1'b0, FIELD_SECOND, 25'd0}},
			'{1'b0, 1'b0, 12'hFFF, 1'b0, NO_READING}
		};
		for (int i = 0; i < N_DIRECTED; i++)
			plan.push_back(directed_ticks[i]);

		// Random part: mostly complete edit sessions, plus plain counting and noise.
		while (plan.size() < N_DIRECTED + N_RANDOM) begin
			r = $urandom_range(0, 99);
			if (r < 30) begin
				repeat ($urandom_range(1, 24))
					plan.push_back('{1'b0, 1'b0, 12'($urandom_range(0, 4095)), 1'b0,
						NO_READING});
			end else if (r < 85) begin
				// Late sessions aim at the last seconds of December 31.
				late = ($urandom_range(0, 3) == 0);
				k = late ? 4 : $urandom_range(1, 6);
				for (int f = 0; f <= k; f++) begin
					w = (!late) ? 12'($urandom_range(0, 4095))
						: (f == 4) ? 12'($urandom_range(3800, 4095)) : 12'hFFF;
					plan.push_back('{1'b1, 1'b0, w, 1'b0, NO_READING});
					repeat ($urandom_range(0, 2)) begin
						w = late ? w : 12'($urandom_range(0, 4095));
						plan.push_back('{1'b0, 1'b0, w, 1'b0, NO_READING});
					end
				end
				if ($urandom_range(0, 9) != 0)
					plan.push_back('{!late && ($urandom_range(0, 5) == 0), 1'b1,
						12'($urandom_range(0, 4095)), 1'b0, NO_READING});
				if (late)
					repeat ($urandom_range(1, 5))
						plan.push_back('{1'b0, 1'b0, 12'($urandom_range(0, 4095)), 1'b0,
							NO_READING});
			end else begin
				repeat ($urandom_range(1, 8))
					plan.push_back('{($urandom_range(0, 3) == 0), ($urandom_range(0, 3) == 0),
						12'($urandom_range(0, 4095)), 1'b0, NO_READING});
			end
		end

		// Model state after reset.
		cal_count = ccwe_pkg::COUNT_RESET;
		cal_month = '0;
		cal_day = '0;
		cal_hour = '0;
		cal_minute = '0;
		cal_second = '0;
		cal_view = VIEW_DATE;
		cal_editing = 1'b0;
		cal_field = FIELD_MONTH;

		repeat (12) @(posedge clk);
		arst_n <= 1'b1;

		while (accepted < plan.size() || pending_readings.size() != 0)
			@(posedge clk);
		repeat (64) @(posedge clk);
		if (fail_count == 0 && pending_readings.size() == 0)
			$display("calendar_clock_with_edit regression: pass");
		else
			$display("calendar_clock_with_edit regression: fail");
		$finish;
	end

	// Watchdog: far beyond the slowest legal run.
	initial begin
		#10000000;
		$display("calendar_clock_with_edit regression: fail");
		$finish;
	end

endmodule
